// ----- design/srp_pkg.sv -----
// shared types, constants and helpers for the shelf atlas rectangle packer
// no dependencies
package srp_pkg;

    localparam int SRP_MAX_SHELVES = 32;
    localparam int DIM_W           = 13;
    localparam int POS_W           = 12;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 24;

    localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd512;
    localparam logic [POS_W-1:0] POS_MAX     = 12'd4095;

    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    // search token handed from cell to cell
    typedef struct packed {
        logic             active;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             hit;
        logic [DIM_W-1:0] hit_space;
        logic [DIM_W-1:0] hit_top;
        logic             fb;
        logic [DIM_W-1:0] fb_space;
        logic [DIM_W-1:0] fb_top;
    } srp_token_t;

    // per-cell update command
    typedef struct packed {
        logic             open_en;
        logic [DIM_W-1:0] open_top;
        logic [DIM_W-1:0] open_height;
        logic [DIM_W-1:0] open_space;
        logic             space_en;
        logic             use_hit;
        logic [DIM_W-1:0] space;
    } srp_update_t;

    function automatic logic [POS_W-1:0] sat_pos(input logic [DIM_W-1:0] v);
        return v[DIM_W-1] ? POS_MAX : v[POS_W-1:0];
    endfunction

endpackage

// ----- design/srp_cell.sv -----
// one shelf of the packer: holds its height, free width and top, checks the passing token
// depends on srp_pkg
module srp_cell
    import srp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        live,
    input  srp_token_t  tok_in,
    output srp_token_t  tok_out,
    input  srp_update_t upd
);

    logic [DIM_W-1:0] height_reg, height_next;
    logic [DIM_W-1:0] space_reg, space_next;
    logic [DIM_W-1:0] top_reg, top_next;
    logic             hit_mark_reg, hit_mark_next;
    logic             fb_mark_reg, fb_mark_next;
    srp_token_t       tok_reg, tok_next;
    logic             fits;
    logic             tall_ok;
    logic             mine;

    assign fits    = (tok_in.h <= height_reg) && (tok_in.w <= space_reg);
    assign tall_ok = tok_in.h >= (height_reg >> 1);
    assign mine    = upd.use_hit ? hit_mark_reg : fb_mark_reg;

    always_comb
    begin
        tok_next      = tok_in;
        hit_mark_next = hit_mark_reg;
        fb_mark_next  = fb_mark_reg;
        if (tok_in.active)
        begin
            hit_mark_next = 1'b0;
            fb_mark_next  = 1'b0;
            if (live && !tok_in.hit && fits)
            begin
                if (tall_ok)
                begin
                    tok_next.hit       = 1'b1;
                    tok_next.hit_space = space_reg;
                    tok_next.hit_top   = top_reg;
                    hit_mark_next      = 1'b1;
                end
                else if (!tok_in.fb)
                begin
                    tok_next.fb       = 1'b1;
                    tok_next.fb_space = space_reg;
                    tok_next.fb_top   = top_reg;
                    fb_mark_next      = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        height_next = height_reg;
        space_next  = space_reg;
        top_next    = top_reg;
        if (upd.open_en)
        begin
            height_next = upd.open_height;
            space_next  = upd.open_space;
            top_next    = upd.open_top;
        end
        else if (upd.space_en && mine)
        begin
            space_next = upd.space;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg       <= '0;
            hit_mark_reg  <= 1'b0;
            fb_mark_reg   <= 1'b0;
        end
        else
        begin
            tok_reg       <= tok_next;
            hit_mark_reg  <= hit_mark_next;
            fb_mark_reg   <= fb_mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        space_reg  <= space_next;
        top_reg    <= top_next;
    end

    assign tok_out = tok_reg;

endmodule

// ----- design/shelf_atlas_rect_packer.sv -----
// shelf atlas rectangle packer: one rectangle in, one placement out
// the input token walks the chain of shelf cells, is captured in res_reg and decided into the output registers;
// one item at a time: a new item is taken only in idle, once the result of the last one is registered,
// and a finished result waits in ST_DONE while an earlier result is not yet taken by m_axis_tready
// reset: no shelves open, used height zero, atlas 512 x 512, no result pending
// depends on srp_pkg and srp_cell
module shelf_atlas_rect_packer
    import srp_pkg::*;
#(
    parameter int MAX_SHELVES = SRP_MAX_SHELVES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // rect_width, rect_height
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pos_x, pos_y
    output logic                   m_axis_tuser    // placed
);

    localparam int CNT_W = $clog2(MAX_SHELVES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    srp_token_t       res_reg, res_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DIM_W-1:0] used_reg, used_next;
    logic [DIM_W-1:0] aw_reg, aw_next;
    logic [DIM_W-1:0] ah_reg, ah_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_placed_reg, out_placed_next;
    logic [POS_W-1:0] out_x_reg, out_x_next;
    logic [POS_W-1:0] out_y_reg, out_y_next;

    srp_token_t       tok_chain [MAX_SHELVES+1];
    srp_token_t       inject;
    srp_update_t      upd_common;
    logic             in_xfer;
    logic             cfg_wr;
    logic             fire;
    logic             can_open;
    logic             do_open;
    logic             do_existing;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] sel_top;
    logic [DIM_W-1:0] x_raw;
    logic [DIM_W:0]   used_sum;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ATLAS_HEIGHT) ? APB_DATA_W'(ah_reg)
                                                    : APB_DATA_W'(aw_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        inject        = '0;
        inject.active = in_xfer;
        inject.w      = s_axis_tdata[DIM_W-1:0];
        inject.h      = s_axis_tdata[2*DIM_W-1:DIM_W];
    end

    assign tok_chain[0] = inject;

    // decision on the captured token
    assign used_sum    = {1'b0, used_reg} + {1'b0, res_reg.h};
    assign can_open    = (count_reg < CNT_W'(MAX_SHELVES)) && (used_sum <= {1'b0, ah_reg})
                         && (res_reg.w <= aw_reg);
    assign do_open     = !res_reg.hit && can_open;
    assign do_existing = res_reg.hit || (!can_open && res_reg.fb);
    assign left        = res_reg.hit ? res_reg.hit_space : res_reg.fb_space;
    assign sel_top     = res_reg.hit ? res_reg.hit_top : res_reg.fb_top;
    assign x_raw       = (aw_reg >= left) ? (aw_reg - left) : '0;
    assign fire        = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        upd_common             = '0;
        upd_common.open_top    = used_reg;
        upd_common.open_height = res_reg.h;
        upd_common.open_space  = aw_reg - res_reg.w;
        upd_common.space_en    = fire && do_existing;
        upd_common.use_hit     = res_reg.hit;
        upd_common.space       = left - res_reg.w;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SHELVES; gi++)
        begin : g_cell
            srp_update_t upd;
            always_comb
            begin
                upd         = upd_common;
                upd.open_en = fire && do_open && (count_reg == CNT_W'(gi));
            end
            srp_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .live    (CNT_W'(gi) < count_reg),
                .tok_in  (tok_chain[gi]),
                .tok_out (tok_chain[gi+1]),
                .upd     (upd)
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        aw_next         = aw_reg;
        ah_next         = ah_reg;
        out_valid_next  = out_valid_reg;
        out_placed_next = out_placed_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;

        if (cfg_wr)
        begin
            if (paddr[2] == REG_ATLAS_HEIGHT)
                ah_next = pwdata[DIM_W-1:0];
            else
                aw_next = pwdata[DIM_W-1:0];
        end

        if (m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok_chain[MAX_SHELVES].active)
                begin
                    res_next   = tok_chain[MAX_SHELVES];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (res_reg.hit || !do_open)
                    begin
                        out_placed_next = do_existing;
                        out_x_next      = do_existing ? sat_pos(x_raw) : '0;
                        out_y_next      = do_existing ? sat_pos(sel_top) : '0;
                    end
                    else
                    begin
                        out_placed_next = 1'b1;
                        out_x_next      = '0;
                        out_y_next      = sat_pos(used_reg);
                        count_next      = count_reg + 1'b1;
                        used_next       = used_sum[DIM_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            aw_reg        <= ATLAS_RESET;
            ah_reg        <= ATLAS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            aw_reg        <= aw_next;
            ah_reg        <= ah_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        out_placed_reg <= out_placed_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_placed_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};

endmodule

// ----- bench/shelf_atlas_rect_packer_test.sv -----
// testbench for shelf_atlas_rect_packer: streams rectangles in, checks every placement
// against a shelf-packing predictor held in a small scoreboard class
// depends on srp_pkg and the packer rtl
module shelf_atlas_rect_packer_test
    import srp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDLE_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned DIM_MASK = (1 << DIM_W) - 1;

    typedef struct packed {
        logic             placed;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } place_t;

    class rect_placement_board;
        place_t      expected_places[$];
        int unsigned atlas_w;
        int unsigned atlas_h;
        int unsigned shelf_h[SRP_MAX_SHELVES];
        int unsigned shelf_left[SRP_MAX_SHELVES];
        int unsigned shelf_top[SRP_MAX_SHELVES];
        int unsigned shelf_count;
        int unsigned used_h;
        int          errors;

        function new();
            atlas_w = ATLAS_RESET;
            atlas_h = ATLAS_RESET;
            shelf_count = 0;
            used_h = 0;
            errors = 0;
        endfunction

        function void set_atlas(logic idx, logic [APB_DATA_W-1:0] data);
            if (idx == REG_ATLAS_WIDTH)
                atlas_w = data[DIM_W-1:0];
            else
                atlas_h = data[DIM_W-1:0];
        endfunction

        function logic [POS_W-1:0] clip_pos(int unsigned v);
            return (v > POS_MAX) ? POS_MAX : v[POS_W-1:0];
        endfunction

        function void put_on_shelf(int unsigned s, int unsigned w);
            int unsigned left;
            int unsigned x;
            place_t      p;
            left = shelf_left[s];
            x = (atlas_w >= left) ? atlas_w - left : 0;
            p.placed = 1'b1;
            p.x = clip_pos(x);
            p.y = clip_pos(shelf_top[s]);
            expected_places.push_back(p);
            shelf_left[s] = (left - w) & DIM_MASK;
        endfunction

        function void note_rect(logic [DIM_W-1:0] w_in, logic [DIM_W-1:0] h_in);
            int unsigned w;
            int unsigned h;
            int unsigned n;
            int unsigned fb;
            bit          have_fb;
            place_t      p;
            w = w_in;
            h = h_in;
            n = shelf_count;
            have_fb = 0;
            fb = 0;
            for (int unsigned s = 0; s < n; s++)
            begin
                if (h > shelf_h[s] || w > shelf_left[s])
                    continue;
                if (h < shelf_h[s] / 2)
                begin
                    if (!have_fb)
                    begin
                        have_fb = 1;
                        fb = s;
                    end
                    continue;
                end
                put_on_shelf(s, w);
                return;
            end
            if (n < SRP_MAX_SHELVES && used_h + h <= atlas_h && w <= atlas_w)
            begin
                shelf_top[n] = used_h;
                shelf_h[n] = h;
                shelf_left[n] = atlas_w;
                shelf_count = n + 1;
                used_h = (used_h + h) & DIM_MASK;
                put_on_shelf(n, w);
                return;
            end
            if (have_fb)
            begin
                put_on_shelf(fb, w);
                return;
            end
            p = '0;
            expected_places.push_back(p);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endfunction

        function void check_place(logic placed, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
            place_t p;
            if (expected_places.size() == 0)
            begin
                report($sformatf("placement %0d,%0d,%0d with nothing expected", placed, x, y));
                return;
            end
            p = expected_places.pop_front();
            if (placed !== p.placed)
                report($sformatf("placed %0d, expected %0d", placed, p.placed));
            if (x !== p.x)
                report($sformatf("pos_x %0d, expected %0d", x, p.x));
            if (y !== p.y)
                report($sformatf("pos_y %0d, expected %0d", y, p.y));
        endfunction

        function int pending();
            return expected_places.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // rect_width, rect_height
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // pos_x, pos_y
    logic                   m_axis_tuser;   // placed

    rect_placement_board board;
    bit                  idle_on;
    bit                  hold_req;
    int                  quiet_cycles;

    shelf_atlas_rect_packer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // most gaps short, a few long
    function automatic int idle_gap();
        if (!idle_on || $urandom_range(0, 2) != 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    task automatic send_rect(input int unsigned w, input int unsigned h, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, h[DIM_W-1:0], w[DIM_W-1:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_rect(w[DIM_W-1:0], h[DIM_W-1:0]);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_atlas(input logic idx, input int unsigned value);
        logic [APB_DATA_W-1:0] data;
        data = $urandom();
        data[DIM_W-1:0] = value[DIM_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_atlas(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // mostly rectangles that reuse shelves, the rest up to 4096 in each dimension
    task automatic run_random(input int n, input int unsigned aw, input int unsigned ah,
                              input int unsigned wf_w, input int unsigned wf_h,
                              input bit idle, input bit hold);
        int unsigned w;
        int unsigned h;
        write_atlas(REG_ATLAS_WIDTH, aw);
        write_atlas(REG_ATLAS_HEIGHT, ah);
        idle_on = idle;
        hold_req = hold;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                w = $urandom_range(0, wf_w);
                h = $urandom_range(1, wf_h);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                w = $urandom_range(0, 1) * 4096;
                h = $urandom_range(0, 1) * 4096;
            end
            else
            begin
                w = $urandom_range(0, 4096);
                h = $urandom_range(0, 4096);
            end
            send_rect(w, h, idle_gap());
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_place(m_axis_tuser, m_axis_tdata[POS_W-1:0],
                              m_axis_tdata[2*POS_W-1:POS_W]);
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_gap() > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (idle_gap() + 1) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        idle_on = 1;
        hold_req = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset atlas: zero sizes, a full-width shelf, too wide, fallback shelf, too tall
        send_rect(0, 0, idle_gap());
        send_rect(512, 10, idle_gap());
        send_rect(513, 5, idle_gap());
        send_rect(0, 10, idle_gap());
        send_rect(100, 40, idle_gap());
        send_rect(50, 20, idle_gap());
        send_rect(50, 19, idle_gap());
        send_rect(4096, 4096, idle_gap());
        send_rect(0, 4096, idle_gap());
        send_rect(511, 1, idle_gap());
        send_rect(8, 2, idle_gap());
        drain_results();

        // full-width shelf then a zero-width rect at its right edge
        write_atlas(REG_ATLAS_WIDTH, 4096);
        write_atlas(REG_ATLAS_HEIGHT, 4096);
        send_rect(4096, 100, idle_gap());
        send_rect(0, 100, idle_gap());
        send_rect(4096, 4096, idle_gap());
        send_rect(0, 0, idle_gap());
        drain_results();

        // atlas narrowed to width 1 with shelves already open
        write_atlas(REG_ATLAS_WIDTH, 1);
        send_rect(0, 10, idle_gap());
        send_rect(1, 10, idle_gap());
        send_rect(2, 5, idle_gap());
        drain_results();

        run_random(90, 4096, 4096, 64, 48, 1, 0);
        run_random(80, 1000, 2500, 128, 32, 0, 1);
        run_random(40, 64, 1, 16, 8, 1, 0);
        run_random(90, 3000, 4096, 64, 64, 1, 0);
        run_random(80, 4096, 4096, 32, 16, 1, 0);

        // oversized registers: shelves below row 4095
        write_atlas(REG_ATLAS_WIDTH, 8191);
        write_atlas(REG_ATLAS_HEIGHT, 8191);
        send_rect(5, 4096, idle_gap());
        send_rect(5, 4096, idle_gap());
        send_rect(0, 4096, idle_gap());
        drain_results();
        run_random(20, 8191, 8191, 64, 64, 1, 0);

        if (board.errors == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/srp_pkg.sv
design/srp_cell.sv
design/shelf_atlas_rect_packer.sv
bench/shelf_atlas_rect_packer_test.sv
